>>> rtl/ius_pkg.sv
`default_nettype none

package ius_pkg;

    localparam int PIX_W       = 24;
    localparam int SCALE_W     = 7;
    localparam int SWIDTH_W    = 12;
    localparam int SHEIGHT_W   = 13;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;
    localparam int PAD_MOD     = 4;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_SCALE  = 100;

    typedef enum logic [1:0] {
        REG_SCALE      = 2'd0,
        REG_SRC_WIDTH  = 2'd1,
        REG_SRC_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SCALE_W-1:0]   scale;
        logic [SWIDTH_W-1:0]  src_width;
        logic [SHEIGHT_W-1:0] src_height;
    } t_cfg;

    typedef struct packed {
        logic             src_valid;
        logic [PIX_W-1:0] src_pixel;
    } t_item;

    typedef struct packed {
        logic             took_pixel;
        logic             emit;
        logic             is_pad;
        logic [PIX_W-1:0] out_pixel;
        logic             row_end;
        logic             frame_end;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ius_in_if.sv
`default_nettype none

interface ius_in_if import ius_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             src_valid;
    logic [PIX_W-1:0] src_pixel;

    modport source (output valid, output src_valid, output src_pixel, input ready);
    modport sink   (input valid, input src_valid, input src_pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/ius_out_if.sv
`default_nettype none

interface ius_out_if import ius_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             took_pixel;
    logic             emit;
    logic             is_pad;
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;

    modport source (
        output valid, output took_pixel, output emit, output is_pad,
        output out_pixel, output row_end, output frame_end, input ready
    );
    modport sink (
        input valid, input took_pixel, input emit, input is_pad,
        input out_pixel, input row_end, input frame_end, output ready
    );
endinterface

`default_nettype wire

>>> rtl/ius_cfg.sv
`default_nettype none

module ius_cfg import ius_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                REG_SCALE:      n_cfg.scale      = pwdata[SCALE_W-1:0];
                REG_SRC_WIDTH:  n_cfg.src_width  = pwdata[SWIDTH_W-1:0];
                REG_SRC_HEIGHT: n_cfg.src_height = pwdata[SHEIGHT_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCALE:      prdata = APB_DW'(r_cfg.scale);
            REG_SRC_WIDTH:  prdata = APB_DW'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_cfg.src_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale      <= SCALE_W'(1);
            r_cfg.src_width  <= SWIDTH_W'(1);
            r_cfg.src_height <= SHEIGHT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ius_lbuf.sv
`default_nettype none

module ius_lbuf import ius_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [PIX_W-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // same-address write forwards so the next copy sees the fresh pixel
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ius_step.sv
`default_nettype none

module ius_step import ius_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire t_cfg             i_cfg,
    input  wire t_item            i_item,
    input  wire logic [PIX_W-1:0] i_rd_data,
    output t_result               o_res,
    output logic                  o_wr_en,
    output logic      [AW-1:0]    o_wr_addr,
    output logic      [PIX_W-1:0] o_wr_data,
    output logic                  o_rd_en,
    output logic      [AW-1:0]    o_rd_addr
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W = $clog2(MAX_SCALE + 1);

    logic [COL_W-1:0] r_column,     n_column;
    logic [CNT_W-1:0] r_copy_count, n_copy_count;
    logic [CNT_W-1:0] r_row_repeat, n_row_repeat;
    logic [ROW_W-1:0] r_source_row, n_source_row;
    logic [1:0]       r_pad_count,  n_pad_count;
    logic             r_in_padding, n_in_padding;

    logic [31:0]      s32, w32, h32;
    logic [CNT_W-1:0] s;
    logic [COL_W-1:0] w;
    logic [ROW_W-1:0] h;
    logic [1:0]       pads;
    logic             fresh;
    logic             take;
    logic             emitting;
    logic             line_done;
    logic             frame_done;
    logic [PIX_W-1:0] value;
    logic [1:0]       pc1;
    logic [CNT_W-1:0] cc1;
    logic [COL_W-1:0] col1;
    logic [CNT_W-1:0] rr1;
    logic [ROW_W-1:0] sr1;

    // zero counts as one, large values clip to the configured maxima
    always_comb begin
        if (i_cfg.scale == '0) begin
            s32 = 32'd1;
        end else if (32'(i_cfg.scale) > 32'(MAX_SCALE)) begin
            s32 = 32'(MAX_SCALE);
        end else begin
            s32 = 32'(i_cfg.scale);
        end
        if (i_cfg.src_width == '0) begin
            w32 = 32'd1;
        end else if (32'(i_cfg.src_width) > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end else begin
            w32 = 32'(i_cfg.src_width);
        end
        if (i_cfg.src_height == '0) begin
            h32 = 32'd1;
        end else if (32'(i_cfg.src_height) > 32'(MAX_HEIGHT)) begin
            h32 = 32'(MAX_HEIGHT);
        end else begin
            h32 = 32'(i_cfg.src_height);
        end
    end

    assign s    = s32[CNT_W-1:0];
    assign w    = w32[COL_W-1:0];
    assign h    = h32[ROW_W-1:0];
    // output row pixels mod 4 reduces to (w mod 4)*(s mod 4) mod 4
    assign pads = 2'(w32[1:0] * s32[1:0]);

    assign fresh = !r_in_padding && (r_row_repeat == '0) && (r_copy_count == '0);
    assign take  = fresh && i_item.src_valid;

    always_comb begin
        n_column     = r_column;
        n_copy_count = r_copy_count;
        n_row_repeat = r_row_repeat;
        n_source_row = r_source_row;
        n_pad_count  = r_pad_count;
        n_in_padding = r_in_padding;
        emitting     = 1'b0;
        line_done    = 1'b0;
        frame_done   = 1'b0;
        value        = '0;
        pc1          = r_pad_count + 2'd1;
        cc1          = r_copy_count + CNT_W'(1);
        col1         = r_column + COL_W'(1);
        rr1          = r_row_repeat + CNT_W'(1);
        sr1          = r_source_row + ROW_W'(1);

        if (r_in_padding) begin
            emitting = 1'b1;
            // a wrapped count also ends padding
            if ((pc1 == 2'd0) || (pc1 >= pads)) begin
                n_in_padding = 1'b0;
                n_pad_count  = 2'd0;
                line_done    = 1'b1;
            end else begin
                n_pad_count = pc1;
            end
        end else if (!fresh || i_item.src_valid) begin
            emitting = 1'b1;
            value    = fresh ? i_item.src_pixel : i_rd_data;
            if (cc1 >= s) begin
                n_copy_count = '0;
                if (col1 >= w) begin
                    n_column = '0;
                    if (pads != 2'd0) begin
                        n_in_padding = 1'b1;
                        n_pad_count  = 2'd0;
                    end else begin
                        line_done = 1'b1;
                    end
                end else begin
                    n_column = col1;
                end
            end else begin
                n_copy_count = cc1;
            end
        end

        if (line_done) begin
            if (rr1 >= s) begin
                n_row_repeat = '0;
                if (sr1 >= h) begin
                    n_source_row = '0;
                    frame_done   = 1'b1;
                end else begin
                    n_source_row = sr1;
                end
            end else begin
                n_row_repeat = rr1;
            end
        end
    end

    always_comb begin
        o_res            = '0;
        o_res.took_pixel = take;
        o_res.emit       = emitting;
        o_res.is_pad     = r_in_padding;
        o_res.out_pixel  = value;
        o_res.row_end    = line_done;
        o_res.frame_end  = frame_done;
    end

    // line store: write the fresh pixel, prefetch the column of the next slot
    assign o_wr_en   = i_adv && take;
    assign o_wr_addr = r_column[AW-1:0];
    assign o_wr_data = i_item.src_pixel;
    assign o_rd_en   = i_adv;
    assign o_rd_addr = n_column[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_copy_count <= '0;
            r_row_repeat <= '0;
            r_source_row <= '0;
            r_pad_count  <= '0;
            r_in_padding <= 1'b0;
        end else if (i_adv) begin
            r_column     <= n_column;
            r_copy_count <= n_copy_count;
            r_row_repeat <= n_row_repeat;
            r_source_row <= n_source_row;
            r_pad_count  <= n_pad_count;
            r_in_padding <= n_in_padding;
        end
    end

endmodule

`default_nettype wire

>>> rtl/integer_pixel_upscaler_top.sv
`default_nettype none

// channel   dir  modport  payload
// i_px      in   sink     src_valid, src_pixel (one request per output slot)
// o_px      out  source   took_pixel, emit, is_pad, out_pixel, row_end, frame_end
// apb       in   slave    scale @0x0, src_width @0x4, src_height @0x8
//
// One request per clock sustained while o_px is ready. A taken request is held in the
// input register, stepped into the result register and then offered on o_px.
// The step logic and the single-write, single-read line store sustain that rate: the
// store read for the next slot is issued as the current one retires, so replayed
// pixels are ready in time.
// Reset is synchronous: counters clear, registers go to 1; the line store is not
// cleared. Output back-pressure holds both registers; i_px.ready drops while the
// input register is full and its request cannot retire.

module integer_pixel_upscaler_top import ius_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = DEF_MAX_SCALE
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    ius_in_if.sink                 i_px,
    ius_out_if.source              o_px
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_cfg             cfg;
    t_item            r_in;
    logic             r_in_valid;
    t_result          r_out;
    logic             r_out_valid;
    t_result          res;
    logic             adv;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;

    ius_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ius_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_cfg     (cfg),
        .i_item    (r_in),
        .i_rd_data (rd_data),
        .o_res     (res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    ius_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // held request retires when the result slot is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || o_px.ready);
    assign i_px.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_px.ready) begin
            r_in_valid <= i_px.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_px.ready && i_px.valid) begin
            r_in.src_valid <= i_px.src_valid;
            r_in.src_pixel <= i_px.src_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_px.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_px.valid      = r_out_valid;
    assign o_px.took_pixel = r_out.took_pixel;
    assign o_px.emit       = r_out.emit;
    assign o_px.is_pad     = r_out.is_pad;
    assign o_px.out_pixel  = r_out.out_pixel;
    assign o_px.row_end    = r_out.row_end;
    assign o_px.frame_end  = r_out.frame_end;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_px.ready)
        else $error("input stalled with empty result register");

    a_pad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_pad) |->
            (r_out.emit && (r_out.out_pixel == '0) && !r_out.took_pixel))
        else $error("padding result carries pixel data");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.row_end && r_out.emit))
        else $error("frame end without row end");

    a_store_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_out_valid && r_out.took_pixel && !r_out.is_pad))
        else $error("line store written without a consumed pixel");

endmodule

`default_nettype wire
